>>> src/erm_pkg.sv
`default_nettype none

package erm_pkg;

	// Fixed port geometry
	localparam int ANGLE_W    = 16;
	localparam int OUT_W      = 18;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 168;

	// pi/2 with a 62-bit fraction
	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

	// (a * b) >> 62, kept to 64 bits
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// Denominator of the k-th sine series step: (2k)(2k+1)
	function automatic logic [63:0] series_div(input int k);
		logic [63:0] kk;
		kk = 64'(k);
		return (64'd2 * kk) * (64'd2 * kk + 64'd1);
	endfunction

	// Unsigned quotient by shift and subtract, one quotient bit per step
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		int b;
		r = '0;
		q = '0;
		for (b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r    = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Quarter-wave sine entry i, rounded to fb fraction bits
	function automatic logic [63:0] sine_entry(input int tb, input int fb, input logic [63:0] i);
		logic [63:0] nm;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		int k;
		nm   = (64'd1 << tb) - 64'd1;
		x    = (HALF_PI_Q62 >> tb) * i + (((HALF_PI_Q62 & nm) * i) >> tb);
		x2   = mul_q62(x, x);
		term = x;
		sum  = x;
		for (k = 1; k <= 12; k++) begin
			term = udiv64(mul_q62(term, x2), series_div(k));
			if ((k & 1) != 0) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return (sum + (64'd1 << (61 - fb))) >> (62 - fb);
	endfunction

endpackage

`default_nettype wire

>>> src/erm_trig.sv
`default_nettype none

module erm_trig #(
	parameter int ANGLE_BITS = 16,
	parameter int FRAC_BITS  = 16,
	parameter int TABLE_BITS = 10
) (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [erm_pkg::ANGLE_W-1:0]  angle,
	output logic signed [FRAC_BITS+1:0]       sin_s2,
	output logic signed [FRAC_BITS+1:0]       cos_s2,
	output logic signed [FRAC_BITS+1:0]       nsin_s2
);

	localparam int EW    = FRAC_BITS + 2;
	localparam int PH_W  = TABLE_BITS + 2;
	localparam int TAB_N = 1 << TABLE_BITS;
	localparam int SH    = ANGLE_BITS - PH_W;
	localparam int AIN   = (ANGLE_BITS < erm_pkg::ANGLE_W) ? ANGLE_BITS : erm_pkg::ANGLE_W;
	localparam logic [TABLE_BITS:0] QUARTER = {1'b1, {TABLE_BITS{1'b0}}};
	localparam logic [EW-1:0]       ONE_FX  = {2'b01, {FRAC_BITS{1'b0}}};

	typedef logic [FRAC_BITS:0] tab_t [TAB_N];

	function automatic tab_t build_tab();
		tab_t t;
		int i;
		for (i = 0; i < TAB_N; i++) begin
			t[i] = (FRAC_BITS+1)'(erm_pkg::sine_entry(TABLE_BITS, FRAC_BITS, 64'(i)));
		end
		return t;
	endfunction

	localparam tab_t SINE_TAB = build_tab();

	logic [ANGLE_BITS:0]   a_ext;
	logic [PH_W-1:0]       ph_s;
	logic [PH_W-1:0]       ph_c;
	logic [TABLE_BITS:0]   idx_s;
	logic [TABLE_BITS:0]   idx_c;
	logic [FRAC_BITS:0]    mag_s_s1;
	logic [FRAC_BITS:0]    mag_c_s1;
	logic                  one_s_s1;
	logic                  one_c_s1;
	logic                  neg_s_s1;
	logic                  neg_c_s1;
	logic [EW-1:0]         mag_s;
	logic [EW-1:0]         mag_c;
	logic signed [EW-1:0]  sin_v;
	logic signed [EW-1:0]  cos_v;

	assign a_ext = (ANGLE_BITS+1)'(angle[AIN-1:0]);

	// Reduce the angle to table phase, rounding half up and wrapping at a full turn
	generate
		if (SH > 0) begin : g_round
			logic [ANGLE_BITS:0] a_rnd;
			assign a_rnd = a_ext + ((ANGLE_BITS+1)'(1) << (SH - 1));
			assign ph_s  = a_rnd[SH +: PH_W];
		end else if (SH == 0) begin : g_same
			assign ph_s = a_ext[PH_W-1:0];
		end else begin : g_widen
			assign ph_s = PH_W'(a_ext[ANGLE_BITS-1:0]) << (PH_W - ANGLE_BITS);
		end
	endgenerate

	// Cosine is sine a quarter turn later
	assign ph_c = ph_s + {2'b01, {TABLE_BITS{1'b0}}};

	// Mirror the index in odd quadrants
	assign idx_s = ph_s[TABLE_BITS] ? (QUARTER - {1'b0, ph_s[TABLE_BITS-1:0]})
	                                : {1'b0, ph_s[TABLE_BITS-1:0]};
	assign idx_c = ph_c[TABLE_BITS] ? (QUARTER - {1'b0, ph_c[TABLE_BITS-1:0]})
	                                : {1'b0, ph_c[TABLE_BITS-1:0]};

	// Table read, registered
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s_s1 <= SINE_TAB[idx_s[TABLE_BITS-1:0]];
			mag_c_s1 <= SINE_TAB[idx_c[TABLE_BITS-1:0]];
			one_s_s1 <= idx_s[TABLE_BITS];
			one_c_s1 <= idx_c[TABLE_BITS];
			neg_s_s1 <= ph_s[PH_W-1];
			neg_c_s1 <= ph_c[PH_W-1];
		end
	end

	// Apply full-scale case and quadrant sign
	assign mag_s = one_s_s1 ? ONE_FX : {1'b0, mag_s_s1};
	assign mag_c = one_c_s1 ? ONE_FX : {1'b0, mag_c_s1};
	assign sin_v = neg_s_s1 ? -$signed(mag_s) : $signed(mag_s);
	assign cos_v = neg_c_s1 ? -$signed(mag_c) : $signed(mag_c);

	always_ff @(posedge clk) begin
		if (en) begin
			sin_s2  <= sin_v;
			cos_s2  <= cos_v;
			nsin_s2 <= -sin_v;
		end
	end

endmodule

`default_nettype wire

>>> src/erm_row.sv
`default_nettype none

module erm_row #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [FRAC_BITS+1:0]   a0,
	input  wire logic signed [FRAC_BITS+1:0]   a1,
	input  wire logic signed [FRAC_BITS+1:0]   a2,
	input  wire logic signed [FRAC_BITS+1:0]   cz,
	input  wire logic signed [FRAC_BITS+1:0]   sz,
	input  wire logic signed [FRAC_BITS+1:0]   nsz,
	output logic signed [FRAC_BITS+1:0]        r0_s6,
	output logic signed [FRAC_BITS+1:0]        r1_s6,
	output logic signed [FRAC_BITS+1:0]        r2_s6
);

	localparam int EW = FRAC_BITS + 2;
	localparam int PW = 2 * EW;
	localparam logic [PW-1:0]     HALF    = PW'(1) << (FRAC_BITS - 1);
	localparam logic signed [EW:0] POS_ONE = {3'b001, {FRAC_BITS{1'b0}}};
	localparam logic signed [EW:0] NEG_ONE = {3'b111, {FRAC_BITS{1'b0}}};

	logic signed [PW-1:0] p0_s5;
	logic signed [PW-1:0] p1_s5;
	logic signed [PW-1:0] p2_s5;
	logic signed [PW-1:0] p3_s5;
	logic signed [EW-1:0] a2_s5;
	logic signed [EW:0]   sum0;
	logic signed [EW:0]   sum1;

	// Round to nearest, ties up
	function automatic logic signed [EW-1:0] rnd(input logic signed [PW-1:0] p);
		logic [PW-1:0] t;
		t = p + HALF;
		return t[FRAC_BITS +: EW];
	endfunction

	function automatic logic signed [EW-1:0] sat(input logic signed [EW:0] v);
		logic signed [EW-1:0] r;
		priority if (v > POS_ONE) begin
			r = POS_ONE[EW-1:0];
		end else if (v < NEG_ONE) begin
			r = NEG_ONE[EW-1:0];
		end else begin
			r = v[EW-1:0];
		end
		return r;
	endfunction

	// Multiply the row by the z rotation columns
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s5 <= a0 * cz;
			p1_s5 <= a1 * sz;
			p2_s5 <= a0 * nsz;
			p3_s5 <= a1 * cz;
			a2_s5 <= a2;
		end
	end

	assign sum0 = (EW+1)'(rnd(p0_s5)) + (EW+1)'(rnd(p1_s5));
	assign sum1 = (EW+1)'(rnd(p2_s5)) + (EW+1)'(rnd(p3_s5));

	// Sum rounded products and clamp to unit range; a2 passes through
	always_ff @(posedge clk) begin
		if (en) begin
			r0_s6 <= sat(sum0);
			r1_s6 <= sat(sum1);
			r2_s6 <= a2_s5;
		end
	end

endmodule

`default_nettype wire

>>> src/euler_rotation_matrix_top.sv
`default_nettype none

// Euler XYZ rotation matrix: each input word carries three binary angles
// (2^ANGLE_BITS is one full turn) and yields one output word holding the nine
// entries of Rx*Ry*Rz, row by row, as signed fixed point with FRAC_BITS
// fraction bits, clamped to +/-1.0 and carried as the low 18 bits of each
// field. The datapath is fully pipelined: one word is accepted every clock
// while the skid stage is empty. Three sine/cosine units, each with two
// reads of a 2^TABLE_BITS-entry quarter-wave ROM, feed a stage of x/y
// products and three row lanes of four multipliers each. An output register
// with a skid stage absorbs one result while the output waits, then stalls input.
module euler_rotation_matrix_top #(
	parameter int ANGLE_BITS = 16,
	parameter int FRAC_BITS  = 16,
	parameter int TABLE_BITS = 10
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// angle_x, angle_y, angle_z
	input  wire logic [erm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// r00, r01, r02, r10, r11, r12, r20, r21, r22, zero pad
	output logic [erm_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);

	localparam int EW    = FRAC_BITS + 2;
	localparam int PW    = 2 * EW;
	localparam int OW    = erm_pkg::OUT_W;
	localparam int XW    = (EW > OW) ? EW : OW;
	localparam int AW    = erm_pkg::ANGLE_W;
	localparam int DW    = erm_pkg::OUT_DATA_W;
	localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic out_v_q, skid_v_q;
	logic [DW-1:0] out_q, skid_q, word;

	logic signed [EW-1:0] sx_s2, cx_s2, nsx_s2;
	logic signed [EW-1:0] sy_s2, cy_s2, nsy_s2;
	logic signed [EW-1:0] sz_s2, cz_s2, nsz_s2;

	logic signed [PW-1:0] p10_s3, p12_s3, p20_s3, p22_s3;
	logic signed [EW-1:0] sx_s3, cx_s3, sy_s3, cy_s3, sz_s3, cz_s3, nsz_s3;
	logic signed [EW-1:0] a10_s4, a12_s4, a20_s4, a22_s4;
	logic signed [EW-1:0] sx_s4, cx_s4, sy_s4, cy_s4, sz_s4, cz_s4, nsz_s4;

	logic signed [EW-1:0] r00_s6, r01_s6, r02_s6;
	logic signed [EW-1:0] r10_s6, r11_s6, r12_s6;
	logic signed [EW-1:0] r20_s6, r21_s6, r22_s6;

	function automatic logic signed [EW-1:0] rnd(input logic signed [PW-1:0] p);
		logic [PW-1:0] t;
		t = p + HALF;
		return t[FRAC_BITS +: EW];
	endfunction

	function automatic logic [OW-1:0] fld(input logic signed [EW-1:0] v);
		logic signed [XW-1:0] x;
		x = XW'(v);
		return x[OW-1:0];
	endfunction

	// Pipeline advances unless the skid stage is holding a word
	assign en            = !skid_v_q;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Sine and cosine, one unit per angle
	erm_trig #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS), .TABLE_BITS(TABLE_BITS)) u_trig_x (
		.clk(clk), .en(en), .angle(s_axis_tdata[AW-1:0]),
		.sin_s2(sx_s2), .cos_s2(cx_s2), .nsin_s2(nsx_s2)
	);
	erm_trig #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS), .TABLE_BITS(TABLE_BITS)) u_trig_y (
		.clk(clk), .en(en), .angle(s_axis_tdata[2*AW-1:AW]),
		.sin_s2(sy_s2), .cos_s2(cy_s2), .nsin_s2(nsy_s2)
	);
	erm_trig #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS), .TABLE_BITS(TABLE_BITS)) u_trig_z (
		.clk(clk), .en(en), .angle(s_axis_tdata[3*AW-1:2*AW]),
		.sin_s2(sz_s2), .cos_s2(cz_s2), .nsin_s2(nsz_s2)
	);

	// Products of Rx*Ry that are not trivially exact
	always_ff @(posedge clk) begin
		if (en) begin
			p10_s3 <= nsx_s2 * nsy_s2;
			p12_s3 <= nsx_s2 * cy_s2;
			p20_s3 <= cx_s2 * nsy_s2;
			p22_s3 <= cx_s2 * cy_s2;
			sx_s3  <= sx_s2;
			cx_s3  <= cx_s2;
			sy_s3  <= sy_s2;
			cy_s3  <= cy_s2;
			sz_s3  <= sz_s2;
			cz_s3  <= cz_s2;
			nsz_s3 <= nsz_s2;
		end
	end

	// Round the intermediate matrix entries
	always_ff @(posedge clk) begin
		if (en) begin
			a10_s4 <= rnd(p10_s3);
			a12_s4 <= rnd(p12_s3);
			a20_s4 <= rnd(p20_s3);
			a22_s4 <= rnd(p22_s3);
			sx_s4  <= sx_s3;
			cx_s4  <= cx_s3;
			sy_s4  <= sy_s3;
			cy_s4  <= cy_s3;
			sz_s4  <= sz_s3;
			cz_s4  <= cz_s3;
			nsz_s4 <= nsz_s3;
		end
	end

	// One lane per result row
	erm_row #(.FRAC_BITS(FRAC_BITS)) u_row0 (
		.clk(clk), .en(en), .a0(cy_s4), .a1('0), .a2(sy_s4),
		.cz(cz_s4), .sz(sz_s4), .nsz(nsz_s4),
		.r0_s6(r00_s6), .r1_s6(r01_s6), .r2_s6(r02_s6)
	);
	erm_row #(.FRAC_BITS(FRAC_BITS)) u_row1 (
		.clk(clk), .en(en), .a0(a10_s4), .a1(cx_s4), .a2(a12_s4),
		.cz(cz_s4), .sz(sz_s4), .nsz(nsz_s4),
		.r0_s6(r10_s6), .r1_s6(r11_s6), .r2_s6(r12_s6)
	);
	erm_row #(.FRAC_BITS(FRAC_BITS)) u_row2 (
		.clk(clk), .en(en), .a0(a20_s4), .a1(sx_s4), .a2(a22_s4),
		.cz(cz_s4), .sz(sz_s4), .nsz(nsz_s4),
		.r0_s6(r20_s6), .r1_s6(r21_s6), .r2_s6(r22_s6)
	);

	// Merge the lane results into one output word
	assign word = {(DW - 9*OW)'(0),
		fld(r22_s6), fld(r21_s6), fld(r20_s6),
		fld(r12_s6), fld(r11_s6), fld(r10_s6),
		fld(r02_s6), fld(r01_s6), fld(r00_s6)};

	// Output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_axis_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= v_s6;
			end
		end else if (v_s6) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_axis_tready) begin
			out_q <= skid_v_q ? skid_q : word;
		end else if (en) begin
			skid_q <= word;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

>>> verif/euler_rotation_matrix_top_test.sv
module euler_rotation_matrix_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ANGLE_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int TABLE_BITS = 10;
	localparam int ANGLE_W    = erm_pkg::ANGLE_W;
	localparam int OUT_W      = erm_pkg::OUT_W;

	localparam int     TAB_N     = 1 << TABLE_BITS;
	localparam int     PH_W      = TABLE_BITS + 2;
	localparam int     ANG_SH    = ANGLE_BITS - TABLE_BITS - 2;
	localparam longint ONE_FX    = longint'(1) << FRAC_BITS;
	localparam longint HALF_LSB  = longint'(1) << (FRAC_BITS - 1);
	localparam logic [63:0] QUARTER_TURN_Q62 = 64'h6487ED5110B4611A;

	localparam time HALF_PERIOD = 5ns;
	localparam int  RESET_CYCLES = 12;
	localparam int  RX_HOLD_CYCLES = 150;
	localparam int  STALL_LIMIT = 1000;
	localparam int  DRAIN_CYCLES = 20;
	localparam int  MAX_REPORTS = 10;

	// nine matrix entries, r00 first
	typedef logic [0:8][OUT_W-1:0] rot_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] ax;
		logic [ANGLE_W-1:0] ay;
		logic [ANGLE_W-1:0] az;
		logic               typed;
		rot_t               mat;
	} angle_row_t;

	localparam logic [OUT_W-1:0] P1 = 18'h10000;
	localparam logic [OUT_W-1:0] N1 = 18'h30000;
	localparam logic [OUT_W-1:0] Z  = 18'h00000;
	localparam rot_t IDENT   = {P1, Z, Z, Z, P1, Z, Z, Z, P1};
	localparam rot_t X_QTR   = {P1, Z, Z, Z, Z, N1, Z, P1, Z};
	localparam rot_t X_HALF  = {P1, Z, Z, Z, N1, Z, Z, Z, N1};
	localparam rot_t Y_QTR   = {Z, Z, P1, Z, P1, Z, N1, Z, Z};
	localparam rot_t Z_QTR   = {Z, N1, Z, P1, Z, Z, Z, Z, P1};
	localparam rot_t Z_3QTR  = {Z, P1, Z, N1, Z, Z, Z, Z, P1};
	localparam rot_t NO_MAT  = '0;

	localparam int DIR_ROWS = 22;
	// directed angle triples; typed rows carry their matrix, the rest use the predictor
	localparam angle_row_t DIR_TAB [DIR_ROWS] = '{
		'{16'd0,     16'd0,     16'd0,     1'b1, IDENT},
		'{16'd16384, 16'd0,     16'd0,     1'b1, X_QTR},
		'{16'd32768, 16'd0,     16'd0,     1'b1, X_HALF},
		'{16'd0,     16'd16384, 16'd0,     1'b1, Y_QTR},
		'{16'd0,     16'd0,     16'd16384, 1'b1, Z_QTR},
		'{16'd0,     16'd0,     16'd49152, 1'b1, Z_3QTR},
		// angles that round up to a full turn
		'{16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1, IDENT},
		'{16'd65528, 16'd65528, 16'd65528, 1'b1, IDENT},
		// just below the rounding threshold
		'{16'd7,     16'd7,     16'd7,     1'b1, IDENT},
		'{16'd8,     16'd8,     16'd8,     1'b0, NO_MAT},
		'{16'd65527, 16'd0,     16'd0,     1'b0, NO_MAT},
		'{16'd0,     16'd65527, 16'd0,     1'b0, NO_MAT},
		'{16'd16384, 16'd16384, 16'd16384, 1'b0, NO_MAT},
		'{16'd8192,  16'd8192,  16'd8192,  1'b0, NO_MAT},
		'{16'd32768, 16'd32768, 16'd32768, 1'b0, NO_MAT},
		'{16'd16376, 16'd16376, 16'd16376, 1'b0, NO_MAT},
		'{16'd16375, 16'd16375, 16'd16375, 1'b0, NO_MAT},
		'{16'd16400, 16'd49160, 16'd32760, 1'b0, NO_MAT},
		'{16'd4096,  16'd12288, 16'd20480, 1'b0, NO_MAT},
		'{16'h5555,  16'hAAAA,  16'h8000,  1'b0, NO_MAT},
		'{16'hAAAA,  16'h5555,  16'h7FFF,  1'b0, NO_MAT},
		'{16'd24576, 16'd40960, 16'd57344, 1'b0, NO_MAT}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// angle_x, angle_y, angle_z
	logic [erm_pkg::IN_DATA_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// r00, r01, r02, r10, r11, r12, r20, r21, r22, zero pad
	logic [erm_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	longint quarter_sine [TAB_N];
	rot_t   expected_matrices [$];
	int     field_errors = 0;
	int     stall_cycles = 0;
	bit     tx_idle_en = 1'b0;
	bit     rx_idle_en = 1'b0;
	int     hold_req = 0;
	int     hold_done = 0;

	euler_rotation_matrix_top #(
		.ANGLE_BITS(ANGLE_BITS),
		.FRAC_BITS (FRAC_BITS),
		.TABLE_BITS(TABLE_BITS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// 62-bit fraction product shifted right by 62, kept to 64 bits
	function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = 128'(a) * 128'(b);
		return 64'(prod >> 62);
	endfunction

	// fill the quarter-wave sine ROM with a Taylor series in Q62
	function automatic void build_quarter_sine();
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] acc;
		for (int i = 0; i < TAB_N; i++) begin
			x = (QUARTER_TURN_Q62 >> TABLE_BITS) * 64'(i) +
			    (((QUARTER_TURN_Q62 & 64'(TAB_N - 1)) * 64'(i)) >> TABLE_BITS);
			x2   = q62_mul(x, x);
			term = x;
			acc  = x;
			for (int k = 1; k <= 12; k++) begin
				term = q62_mul(term, x2) / (64'(2 * k) * 64'(2 * k + 1));
				if (k % 2 == 1) begin
					acc = acc - term;
				end else begin
					acc = acc + term;
				end
			end
			quarter_sine[i] = longint'((acc + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
		end
	endfunction

	// sine of a phase, with quadrant folding
	function automatic longint phase_sine(input logic [PH_W-1:0] ph);
		logic [1:0] quad;
		int idx;
		longint mag;
		quad = ph[PH_W-1 -: 2];
		idx  = int'(ph[TABLE_BITS-1:0]);
		if (quad[0]) begin
			idx = TAB_N - idx;
		end
		mag = (idx >= TAB_N) ? ONE_FX : quarter_sine[idx];
		return quad[1] ? -mag : mag;
	endfunction

	// product rounded to nearest, ties up
	function automatic longint fx_mul(input longint a, input longint b);
		return (a * b + HALF_LSB) >>> FRAC_BITS;
	endfunction

	// 3x3 product with rounded terms, each entry clamped to +/-1.0
	function automatic void mat_prod(input longint a [3][3], input longint b [3][3],
	                                 output longint c [3][3]);
		longint acc;
		for (int r = 0; r < 3; r++) begin
			for (int col = 0; col < 3; col++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) begin
					acc += fx_mul(a[r][k], b[k][col]);
				end
				c[r][col] = (acc > ONE_FX) ? ONE_FX : ((acc < -ONE_FX) ? -ONE_FX : acc);
			end
		end
	endfunction

	// rotation Rx*Ry*Rz for one angle triple
	function automatic rot_t predict_rotation(input logic [ANGLE_W-1:0] ax,
	                                          input logic [ANGLE_W-1:0] ay,
	                                          input logic [ANGLE_W-1:0] az);
		logic [ANGLE_W-1:0] ang [3];
		logic [PH_W-1:0] ph;
		longint sn [3];
		longint cs [3];
		longint rx [3][3];
		longint ry [3][3];
		longint rz [3][3];
		longint xy [3][3];
		longint m [3][3];
		rot_t res;
		ang[0] = ax;
		ang[1] = ay;
		ang[2] = az;
		for (int i = 0; i < 3; i++) begin
			ph    = PH_W'((32'(ang[i]) + (32'd1 << (ANG_SH - 1))) >> ANG_SH);
			sn[i] = phase_sine(ph);
			cs[i] = phase_sine(ph + PH_W'(TAB_N));
		end
		rx = '{'{ONE_FX, 0, 0}, '{0, cs[0], -sn[0]}, '{0, sn[0], cs[0]}};
		ry = '{'{cs[1], 0, sn[1]}, '{0, ONE_FX, 0}, '{-sn[1], 0, cs[1]}};
		rz = '{'{cs[2], -sn[2], 0}, '{sn[2], cs[2], 0}, '{0, 0, ONE_FX}};
		mat_prod(rx, ry, xy);
		mat_prod(xy, rz, m);
		for (int r = 0; r < 3; r++) begin
			for (int col = 0; col < 3; col++) begin
				res[r * 3 + col] = OUT_W'(m[r][col]);
			end
		end
		return res;
	endfunction

	// random angle, biased toward quadrant edges and rounding boundaries
	function automatic logic [ANGLE_W-1:0] pick_angle();
		unique case ($urandom_range(9))
			0: return ANGLE_W'($urandom_range(3) * 16384 + $urandom_range(16) - 8);
			1: return ANGLE_W'(($urandom_range(4095) << 4) | ($urandom_range(1) ? 7 : 8));
			2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
			default: return ANGLE_W'($urandom);
		endcase
	endfunction

	// offer one word, hold it until accepted, then record its expected matrix
	task automatic send_angles(input logic [ANGLE_W-1:0] ax, input logic [ANGLE_W-1:0] ay,
	                           input logic [ANGLE_W-1:0] az, input logic typed,
	                           input rot_t mat);
		@(negedge clk);
		while (tx_idle_en && $urandom_range(99) < 26) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {az, ay, ax};
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		expected_matrices.push_back(typed ? mat : predict_rotation(ax, ay, az));
	endtask

	task automatic send_random(input int count);
		for (int n = 0; n < count; n++) begin
			send_angles(pick_angle(), pick_angle(), pick_angle(), 1'b0, NO_MAT);
		end
	endtask

	// drop valid and wait for every outstanding matrix
	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_matrices.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// receiver: random ready, with an occasional long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
				hold_done = hold_req;
			end else if (rx_idle_en && $urandom_range(99) < 26) begin
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// check each output word against the oldest expectation; watchdog
	always @(posedge clk) begin
		rot_t want;
		logic [OUT_W-1:0] got;
		if (arst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
			if (expected_matrices.size() == 0) begin
				field_errors++;
				if (field_errors <= MAX_REPORTS) begin
					$display("unexpected output word %h", m_axis_tdata);
				end
			end else begin
				want = expected_matrices.pop_front();
				for (int f = 0; f < 9; f++) begin
					got = m_axis_tdata[f * OUT_W +: OUT_W];
					if (got !== want[f]) begin
						field_errors++;
						if (field_errors <= MAX_REPORTS) begin
							$display("r%0d%0d mismatch: expected %0d, got %0d",
							         f / 3, f % 3, $signed(want[f]), $signed(got));
						end
					end
				end
			end
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		arst_n        = 1'b0;
		build_quarter_sine();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		foreach (DIR_TAB[i]) begin
			send_angles(DIR_TAB[i].ax, DIR_TAB[i].ay, DIR_TAB[i].az, DIR_TAB[i].typed,
			            DIR_TAB[i].mat);
		end
		drain_results();

		// receiver holds off while the sender keeps offering
		hold_req++;
		send_random(150);

		// long stretch with no idling on either side
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		send_random(120);
		drain_results();

		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		send_random(130);
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (field_errors == 0 && expected_matrices.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
